### hw/rtl/pida_pkg.sv
// ----------------------------------------------------------------------------
// pida_pkg
// Types and codes shared by the positional insert/delete list.
// ----------------------------------------------------------------------------
package pida_pkg;

  // Wide enough for positions and counts of any list depth up to 64.
  localparam int POS_W = 7;

  typedef enum logic [2:0] {
    CMD_INSERT  = 3'd0,
    CMD_DELETE  = 3'd1,
    CMD_PUSH    = 3'd2,
    CMD_POP     = 3'd3,
    CMD_DISPLAY = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DELETE,
    OP_ROTATE
  } cell_op_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_SHOW
  } fsm_t;

  typedef struct packed {
    logic [2:0]         command;
    logic [4:0]         index;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] element;
    logic [4:0]         count_now;
    logic               last;
  } rsp_t;

  // Broadcast from the controller to every cell of the chain.
  typedef struct packed {
    cell_op_t           op;
    logic [POS_W-1:0]   idx;
    logic [POS_W-1:0]   cnt;
    logic signed [31:0] value;
  } cell_ctrl_t;

endpackage

### hw/rtl/pida_req_if.sv
// ----------------------------------------------------------------------------
// pida_req_if
// Valid/ready channel carrying one command to the list.
// ----------------------------------------------------------------------------
interface pida_req_if;
  import pida_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

### hw/rtl/pida_rsp_if.sv
// ----------------------------------------------------------------------------
// pida_rsp_if
// Valid/ready channel carrying one result from the list.
// ----------------------------------------------------------------------------
interface pida_rsp_if;
  import pida_pkg::*;

  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

### hw/rtl/positional_insert_delete_array.sv
// ----------------------------------------------------------------------------
// positional_insert_delete_array
// Ordered list of signed 32-bit values with insert, delete, push, pop and
// display commands.
//
// Insert, delete, push and pop each give one result transfer: the cells that
// the edit covers all take their new values in the same clock, so the
// command is accepted, the list is edited and the result is registered at
// one edge, and the next command can follow in the next cycle if that result is taken.
// Display of a list of N entries gives N results: after the command is taken,
// one result transfer per cycle while the receiver takes them, set by
// the single read point at the head of the chain: the chain rotates by one
// place per result and is back in its original order when the last result is
// loaded. No new command is accepted during a display. A display of an empty
// list gives one result with status empty. Rejected commands
// leave the list untouched. The cells hold no reset value; the count is
// cleared by reset.
// ----------------------------------------------------------------------------
module positional_insert_delete_array #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  pida_req_if.sink    request,
  pida_rsp_if.source  response
);
  import pida_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] COUNT_FULL = CW'(DEPTH);
  localparam logic [CW-1:0] COUNT_ONE  = CW'(1);

  // Control state.
  fsm_t          state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] rem, rem_next;
  logic          out_valid, out_valid_next;

  // Result register.
  rsp_t          out_data;

  logic          slot_free;
  logic          accept;
  logic          load;
  logic [1:0]    ld_status;
  logic signed [31:0] ld_elem;
  logic          ld_last;

  cell_ctrl_t    ctrl;
  logic signed [31:0] cell_data [DEPTH];

  // The result register may be refilled in the cycle its content is taken.
  assign slot_free     = !out_valid || response.ready;
  assign request.ready = (state == FSM_IDLE) && slot_free;
  assign accept        = request.valid && request.ready;

  assign response.valid = out_valid;
  assign response.data  = out_data;

  // --------------------------------------------------------------------------
  // Chain of cells. Each cell sees its left neighbour (for insert), its right
  // neighbour (for delete and rotate) and the head cell (for the wrap).
  // --------------------------------------------------------------------------
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [31:0] prev_w;
    logic signed [31:0] next_w;

    if (g == 0) begin : g_first
      assign prev_w = request.data.value;
    end else begin : g_mid
      assign prev_w = cell_data[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign next_w = '0;
    end else begin : g_body
      assign next_w = cell_data[g+1];
    end

    pida_cell #(
      .POS (g)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .prev_data (prev_w),
      .next_data (next_w),
      .wrap_data (cell_data[0]),
      .data      (cell_data[g])
    );
  end

  // --------------------------------------------------------------------------
  // Command decode, status checks and display sequencing.
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    count_next = count;
    rem_next   = rem;
    load       = 1'b0;
    ld_status  = ST_OK;
    ld_elem    = '0;
    ld_last    = 1'b1;
    ctrl.op    = OP_HOLD;
    ctrl.idx   = POS_W'(request.data.index);
    ctrl.cnt   = POS_W'(count);
    ctrl.value = request.data.value;

    unique case (state)
      FSM_IDLE: begin
        if (accept) begin
          load = 1'b1;
          unique case (request.data.command)
            CMD_INSERT: begin
              // The index is checked before fullness.
              if (POS_W'(request.data.index) > POS_W'(count)) begin
                ld_status = ST_RANGE;
              end else if (count == COUNT_FULL) begin
                ld_status = ST_FULL;
              end else begin
                ctrl.op    = OP_INSERT;
                count_next = count + COUNT_ONE;
              end
            end
            CMD_DELETE: begin
              // An empty list is reported before a bad index.
              if (count == '0) begin
                ld_status = ST_EMPTY;
              end else if (POS_W'(request.data.index) >= POS_W'(count)) begin
                ld_status = ST_RANGE;
              end else begin
                ctrl.op    = OP_DELETE;
                count_next = count - COUNT_ONE;
              end
            end
            CMD_PUSH: begin
              if (count == COUNT_FULL) begin
                ld_status = ST_FULL;
              end else begin
                ctrl.op    = OP_INSERT;
                ctrl.idx   = POS_W'(count);
                count_next = count + COUNT_ONE;
              end
            end
            CMD_POP: begin
              if (count == '0) begin
                ld_status = ST_EMPTY;
              end else begin
                count_next = count - COUNT_ONE;
              end
            end
            CMD_DISPLAY: begin
              if (count == '0) begin
                ld_status = ST_EMPTY;
              end else begin
                // Results come from the head cell in the following cycles.
                load       = 1'b0;
                rem_next   = count;
                state_next = FSM_SHOW;
              end
            end
            default: begin
              ld_status = ST_RANGE;
            end
          endcase
        end
      end
      FSM_SHOW: begin
        if (slot_free) begin
          load     = 1'b1;
          ld_elem  = cell_data[0];
          ld_last  = (rem == COUNT_ONE);
          ctrl.op  = OP_ROTATE;
          rem_next = rem - COUNT_ONE;
          if (rem == COUNT_ONE) begin
            state_next = FSM_IDLE;
          end
        end
      end
      default: begin
        state_next = FSM_IDLE;
      end
    endcase

    if (load) begin
      out_valid_next = 1'b1;
    end else if (response.ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= FSM_IDLE;
      count     <= '0;
      rem       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rem       <= rem_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.status    <= ld_status;
      out_data.element   <= ld_elem;
      out_data.count_now <= 5'(count_next);
      out_data.last      <= ld_last;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_FULL)
    else $error("entry count exceeds list depth");

  a_show_blocks : assert property (@(posedge clk) disable iff (rst)
    state == FSM_SHOW |-> !request.ready)
    else $error("command accepted during display");

  a_count_stable : assert property (@(posedge clk) disable iff (rst)
    state == FSM_SHOW |=> count == $past(count))
    else $error("count changed during display");

  a_mid_result : assert property (@(posedge clk) disable iff (rst)
    response.valid && !response.data.last |-> state == FSM_SHOW)
    else $error("non-final result outside display");

  a_rem_nonzero : assert property (@(posedge clk) disable iff (rst)
    state == FSM_SHOW |-> rem != '0)
    else $error("display running with nothing left to show");

endmodule

### hw/rtl/pida_cell.sv
// ----------------------------------------------------------------------------
// pida_cell
// One list entry; takes its neighbour's value when the chain shifts.
// ----------------------------------------------------------------------------
module pida_cell #(
  parameter int POS = 0
) (
  input  logic                clk,
  input  pida_pkg::cell_ctrl_t ctrl,
  input  logic signed [31:0]  prev_data,
  input  logic signed [31:0]  next_data,
  input  logic signed [31:0]  wrap_data,
  output logic signed [31:0]  data
);
  import pida_pkg::*;

  localparam logic [POS_W-1:0] MY_POS    = POS_W'(POS);
  localparam logic [POS_W-1:0] MY_POS_P1 = POS_W'(POS + 1);

  logic signed [31:0] data_next;

  always_comb begin
    data_next = data;
    unique case (ctrl.op)
      OP_INSERT: begin
        if (MY_POS == ctrl.idx) begin
          data_next = ctrl.value;
        end else if (MY_POS > ctrl.idx && MY_POS <= ctrl.cnt) begin
          data_next = prev_data;
        end
      end
      OP_DELETE: begin
        if (MY_POS >= ctrl.idx && MY_POS_P1 < ctrl.cnt) begin
          data_next = next_data;
        end
      end
      OP_ROTATE: begin
        // The head entry wraps round to the tail of the occupied part.
        if (MY_POS_P1 < ctrl.cnt) begin
          data_next = next_data;
        end else if (MY_POS_P1 == ctrl.cnt) begin
          data_next = wrap_data;
        end
      end
      default: begin
        data_next = data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the positional insert/delete list. A scoreboard
// keeps its own copy of the list, works out every result that each accepted
// command should give and checks the result transfers in order. The bench
// runs directed corner cases and then random command sequences under several
// patterns of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pida_pkg::*;

  // The list depth that the block is built with. The scoreboard uses the same
  // value to decide when the list is full.
  localparam int LIST_DEPTH = 16;

  // Command codes above display are not defined. The block must answer each
  // of them with a single out-of-range result and leave the list alone.
  localparam logic [2:0] CMD_UNDEF_FIRST = 3'd5;
  localparam logic [2:0] CMD_UNDEF_LAST  = 3'd7;

  // Widest random index: every value of the 5-bit field can be driven.
  localparam int INDEX_MAX = 31;

  // The run is cut off here if it has not ended by itself. The slowest
  // correct run is a few hundred commands, each of which can give up to
  // sixteen results that each wait out a stalling receiver, so this is many
  // times that.
  localparam int CYCLE_LIMIT = 400000;

  // Cycles allowed after the last expected result, so that a stray transfer
  // still has a chance to show up and be flagged.
  localparam int SETTLE_CYCLES = 20;

  // Random commands in each idling phase, at the least; the last run may go past it.
  localparam int PHASE_ITEMS = 45;

  // --------------------------------------------------------------------------
  // Scoreboard. It holds its own copy of the list as a queue of values. Each
  // accepted command edits that copy and queues the results that it should
  // cause; each result transfer from the block is then checked against the
  // oldest of those.
  // --------------------------------------------------------------------------
  class list_scoreboard;
    logic signed [31:0] entries[$];
    rsp_t               awaited[$];
    int unsigned        mismatches;

    function int fill_level();
      return entries.size();
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // One line for each of the first few dozen mismatches; all are counted.
    task report(string msg);
      mismatches++;
      if (mismatches <= 50) begin
        $display("[%0t] mismatch: %s", $realtime, msg);
      end
    endtask

    function void queue_result(status_t st, logic signed [31:0] elem, bit is_last);
      rsp_t r;
      r.status    = st;
      r.element   = elem;
      r.count_now = 5'(entries.size());
      r.last      = is_last;
      awaited.push_back(r);
    endfunction

    function void note_request(req_t req);
      status_t st;
      int      used;
      used = entries.size();
      st   = ST_OK;
      case (req.command)
        CMD_INSERT: begin
          // The index is checked before fullness.
          if (req.index > used) begin
            st = ST_RANGE;
          end else if (used >= LIST_DEPTH) begin
            st = ST_FULL;
          end else begin
            entries.insert(int'(req.index), req.value);
          end
        end
        CMD_DELETE: begin
          // An empty list is reported before a bad index.
          if (used == 0) begin
            st = ST_EMPTY;
          end else if (req.index >= used) begin
            st = ST_RANGE;
          end else begin
            entries.delete(int'(req.index));
          end
        end
        CMD_PUSH: begin
          if (used >= LIST_DEPTH) begin
            st = ST_FULL;
          end else begin
            entries.push_back(req.value);
          end
        end
        CMD_POP: begin
          if (used == 0) begin
            st = ST_EMPTY;
          end else begin
            void'(entries.pop_back());
          end
        end
        CMD_DISPLAY: begin
          if (used == 0) begin
            st = ST_EMPTY;
          end else begin
            for (int i = 0; i < used; i++) begin
              queue_result(ST_OK, entries[i], i == used - 1);
            end
            return;
          end
        end
        default: begin
          st = ST_RANGE;
        end
      endcase
      queue_result(st, '0, 1'b1);
    endfunction

    task check_response(rsp_t got);
      rsp_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result with nothing awaited: status %0d element %0d",
                         got.status, got.element));
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status) begin
        report($sformatf("status %0d, expected %0d", got.status, want.status));
      end
      if (got.element !== want.element) begin
        report($sformatf("element %0d, expected %0d", got.element, want.element));
      end
      if (got.count_now !== want.count_now) begin
        report($sformatf("count_now %0d, expected %0d", got.count_now,
                         want.count_now));
      end
      if (got.last !== want.last) begin
        report($sformatf("last %0b, expected %0b", got.last, want.last));
      end
    endtask
  endclass

  // Broad shape of a random sequence: mostly adding, mostly removing, or a
  // blend of all commands.
  typedef enum int {
    DRIFT_GROW,
    DRIFT_SHRINK,
    DRIFT_BLEND
  } drift_t;

  logic clk = 1'b0;
  logic rst;

  pida_req_if req_ch ();
  pida_rsp_if rsp_ch ();

  list_scoreboard sb;

  // Percentages of cycles in which the sender holds back and in which the
  // receiver refuses a transfer; set per phase by the stimulus.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int cycle_count    = 0;

  positional_insert_delete_array #(
    .DEPTH(LIST_DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .request  (req_ch),
    .response (rsp_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog: a run that hangs is a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL positional_insert_delete_array");
      $finish;
    end
  end

  // Receiving side. Every result transfer is checked at the edge where it
  // happens, and ready is then chosen afresh for the next cycle according to
  // the current stall rate.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
        sb.check_response(rsp_ch.data);
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic req_t make_req(logic [2:0] cmd, int idx, logic signed [31:0] val);
    req_t r;
    r.command = cmd;
    r.index   = 5'(idx);
    r.value   = val;
    return r;
  endfunction

  // Values lean towards the extremes now and then so that the sign bit and
  // the all-ones and all-zeros patterns turn up often.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Picks a command that fits the current fill level of the list most of the
  // time, so that long sequences reach a full list and drain back to empty.
  // A small share is deliberately bad: undefined commands and wild indexes.
  function automatic req_t random_command(drift_t drift);
    int used;
    int roll;
    int add_pct;
    int remove_pct;
    int idx;
    logic [2:0] cmd;
    used = sb.fill_level();
    roll = $urandom_range(99);
    case (drift)
      DRIFT_GROW:   begin add_pct = 75; remove_pct = 12; end
      DRIFT_SHRINK: begin add_pct = 15; remove_pct = 70; end
      default:      begin add_pct = 42; remove_pct = 42; end
    endcase
    if (roll < 5) begin
      cmd = 3'($urandom_range(CMD_UNDEF_FIRST, CMD_UNDEF_LAST));
    end else if (roll < add_pct) begin
      cmd = $urandom_range(1) ? CMD_INSERT : CMD_PUSH;
    end else if (roll < add_pct + remove_pct) begin
      cmd = $urandom_range(1) ? CMD_DELETE : CMD_POP;
    end else begin
      cmd = CMD_DISPLAY;
    end
    if ($urandom_range(99) < 10) begin
      idx = $urandom_range(INDEX_MAX);
    end else if (cmd == CMD_DELETE && used > 0) begin
      idx = $urandom_range(used - 1);
    end else begin
      idx = $urandom_range(used);
    end
    return make_req(cmd, idx, pick_value());
  endfunction

  // Presents one command and waits for its transfer. Before it the sender may
  // go quiet for a random number of cycles. Valid is left high afterwards so
  // that back-to-back commands run without a bubble; whoever stops sending
  // lowers it.
  task automatic send(req_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= item;
    do begin
      @(posedge clk);
    end while (req_ch.ready !== 1'b1);
    sb.note_request(item);
  endtask

  // Holds the sender back until every awaited result has arrived.
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  // One phase of random sequences. Each sequence has its own drift and
  // length; the first phase opens with a long growing run so that the full
  // list is reached early.
  task automatic random_phase(int idle_pct, int stall_pct, bit open_with_growth);
    int     sent;
    int     run_len;
    drift_t drift;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      if (open_with_growth && sent == 0) begin
        drift   = DRIFT_GROW;
        run_len = 30;
      end else begin
        drift   = drift_t'($urandom_range(2));
        run_len = $urandom_range(6, 24);
      end
      repeat (run_len) begin
        send(random_command(drift));
      end
      sent += run_len;
    end
    drain();
  endtask

  initial begin
    sb = new;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part, with no idling on either side. It starts on the empty
    // list, builds a short list at both ends and in the middle, and tries
    // each way in which a command can be refused short of a full list.
    send(make_req(CMD_DISPLAY, 0, '0));            // display of an empty list
    send(make_req(CMD_POP, 0, '0));                // pop from an empty list
    send(make_req(CMD_DELETE, 0, '0));             // delete from an empty list
    send(make_req(CMD_INSERT, 1, 32'sd5));         // insert past the end
    send(make_req(CMD_INSERT, 0, 32'sh8000_0000)); // insert into an empty list
    send(make_req(CMD_PUSH, 0, 32'sh7fff_ffff));
    send(make_req(CMD_INSERT, 2, '1));             // index equal to the count
    send(make_req(CMD_INSERT, 1, 32'sh5a5a_a5a5)); // insert in the middle
    send(make_req(CMD_DISPLAY, 0, '0));
    send(make_req(CMD_DELETE, 4, '0));             // index equal to the count
    send(make_req(CMD_DELETE, INDEX_MAX, '0));     // widest index
    send(make_req(CMD_DELETE, 1, '0));             // delete from the middle
    send(make_req(CMD_DELETE, 0, '0));             // delete the first entry
    for (int c = CMD_UNDEF_FIRST; c <= CMD_UNDEF_LAST; c++) begin
      send(make_req(3'(c), INDEX_MAX, '1));        // undefined commands
    end
    send(make_req(CMD_DISPLAY, 0, '0));
    send(make_req(CMD_POP, 0, '0));
    send(make_req(CMD_DISPLAY, 0, '0));
    drain();

    // Random part. The full list, and pushes and inserts into it, come from
    // the growing runs. Every phase ends with the sender waiting for all its
    // results.
    random_phase(0, 0, 1'b1);
    random_phase(56, 0, 1'b0);
    random_phase(0, 56, 1'b0);
    random_phase(37, 37, 1'b0);

    // All results are in; give any stray transfer time to appear.
    recv_stall_pct = 0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.report($sformatf("%0d results never arrived", sb.pending()));
    end
    if (sb.mismatches == 0) begin
      $display("PASS positional_insert_delete_array");
    end else begin
      $display("FAIL positional_insert_delete_array");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/pida_pkg.sv
hw/rtl/pida_req_if.sv
hw/rtl/pida_rsp_if.sv
hw/rtl/pida_cell.sv
hw/rtl/positional_insert_delete_array.sv
tb/tb_top.sv
